@@ design/swc_pkg.sv @@
// ----------------------------------------------------------------------------
// swc_pkg
// shared widths, codes and fixed-point helpers of the swept box collision unit
// ----------------------------------------------------------------------------
package swc_pkg;

  localparam int CoordW  = 32;                 // signed Q coordinate width
  localparam int FracW   = 16;                 // fraction bits
  localparam int TimeW   = CoordW - 1;         // unsigned time / size width
  localparam int CfgW    = CoordW - 1;         // widest configuration register
  localparam int MagW    = CoordW;             // magnitude of a coordinate
  localparam int ProdW   = TimeW + MagW;       // time times magnitude
  localparam int DivLat  = TimeW + 1;          // divider register stages
  localparam int RegIdxW = 2;

  // register indexes
  localparam logic [RegIdxW-1:0] RegBoxHalfW  = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegBoxHalfH  = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegBallHalfW = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegBallHalfH = RegIdxW'(3);

  // side codes
  localparam logic [2:0] SideNone   = 3'd0;
  localparam logic [2:0] SideTop    = 3'd1;
  localparam logic [2:0] SideBottom = 3'd2;
  localparam logic [2:0] SideLeft   = 3'd3;
  localparam logic [2:0] SideRight  = 3'd4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW+1:0] wide_t;
  typedef logic signed [CoordW:0]   sprod_t;
  typedef logic [TimeW-1:0]         time_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [ProdW-1:0]         prod_t;

  function automatic wide_t sx(input coord_t v);
    return {{2{v[CoordW-1]}}, v};
  endfunction

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v[CoordW+1:CoordW-1] == 3'b000 || v[CoordW+1:CoordW-1] == 3'b111) begin
      r = v[CoordW-1:0];
    end else if (v[CoordW+1]) begin
      r = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic mag_t mag(input coord_t v);
    coord_t a;
    a = v[CoordW-1] ? -v : v;
    return mag_t'(a);
  endfunction

  function automatic mag_t mag_wide(input wide_t v);
    wide_t a;
    a = v[CoordW+1] ? -v : v;
    return a[MagW-1:0];
  endfunction

  // scale a magnitude product back to Q, clamp, apply the sign
  function automatic sprod_t qmul_fin(input prod_t m, input logic neg);
    logic [ProdW-FracW-1:0] sh;
    logic [CoordW-1:0]      c;
    sprod_t                 r;
    sh = m[ProdW-1:FracW];
    if (|sh[ProdW-FracW-1:CoordW-1]) begin
      c = neg ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      c = {1'b0, sh[CoordW-2:0]};
    end
    r = $signed({1'b0, c});
    return neg ? -r : r;
  endfunction

endpackage

@@ design/swc_div.sv @@
// ----------------------------------------------------------------------------
// swc_div
// pipelined restoring divider, quotient = (num << frac) / den, saturated
// ----------------------------------------------------------------------------
module swc_div (
  input  logic           clk_i,
  input  logic           en_i,
  input  swc_pkg::mag_t  num_i,
  input  swc_pkg::mag_t  den_i,
  output swc_pkg::time_t quo_o
);

  localparam int ShW = swc_pkg::TimeW - swc_pkg::FracW;

  logic [swc_pkg::MagW-1:0] rem_q  [swc_pkg::DivLat];
  swc_pkg::time_t           quo_q  [swc_pkg::DivLat];
  swc_pkg::time_t           bits_q [swc_pkg::DivLat];
  swc_pkg::mag_t            den_q  [swc_pkg::DivLat];
  logic                     ovf_q  [swc_pkg::DivLat];

  // quotient does not fit when num >= den << ShW
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= {{ShW{1'b0}}, num_i} >= {den_i, {ShW{1'b0}}};
      rem_q[0]  <= swc_pkg::MagW'(num_i[swc_pkg::MagW-1:ShW]);
      bits_q[0] <= {num_i[ShW-1:0], {swc_pkg::FracW{1'b0}}};
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
    end
  end

  for (genvar k = 1; k < swc_pkg::DivLat; k++) begin : g_step
    logic [swc_pkg::MagW:0] trial;
    logic [swc_pkg::MagW:0] diff;
    logic                   ge;
    assign trial = {rem_q[k-1], bits_q[k-1][swc_pkg::TimeW-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};
    assign diff  = trial - {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[swc_pkg::MagW-1:0] : trial[swc_pkg::MagW-1:0];
        quo_q[k]  <= {quo_q[k-1][swc_pkg::TimeW-2:0], ge};
        bits_q[k] <= {bits_q[k-1][swc_pkg::TimeW-2:0], 1'b0};
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = ovf_q[swc_pkg::DivLat-1] ? {swc_pkg::TimeW{1'b1}}
                                          : quo_q[swc_pkg::DivLat-1];

endmodule

@@ design/swept_box_collision_unit.sv @@
// ----------------------------------------------------------------------------
// swept_box_collision_unit
// swept box vs ball hit test, signed Q16.16, unless stalled one pair per clock
// ----------------------------------------------------------------------------
// Takes one box/ball pair per clock while the pipeline advances and returns
// one result transfer per pair, in order. Depth is set by the two 32-stage
// hit time dividers (an operand stage, then one quotient bit per stage), one
// for each axis; the rest of the path is eight register stages of adds, 31x32
// multiplies and compares, plus the output register. The whole pipeline
// advances only when the output register is empty or being taken, so
// backpressure stalls every stage together and nothing is dropped or
// repeated. Half sizes are to be written through the cfg port only while no
// pair is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module swept_box_collision_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_we_i,
  input  logic [swc_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [swc_pkg::CfgW-1:0]        cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // box_x, box_y, box_vel_x, box_vel_y, ball_x, ball_y,
  // ball_vel_x, ball_vel_y, time_limit, zero pad
  input  logic [287:0]                    s_axis_tdata,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit, side, hit_time, contact_x, contact_y, zero pad
  output logic [103:0]                    m_axis_tdata
);

  localparam int CW = swc_pkg::CoordW;
  localparam int TW = swc_pkg::TimeW;

  // sideband that rides along the dividers
  typedef struct packed {
    swc_pkg::time_t  limit;
    swc_pkg::coord_t bvx;
    swc_pkg::coord_t bvy;
    swc_pkg::coord_t px;
    swc_pkg::coord_t py;
    swc_pkg::coord_t rvx;
    swc_pkg::coord_t rvy;
    swc_pkg::coord_t left;
    swc_pkg::coord_t right;
    swc_pkg::coord_t bottom;
    swc_pkg::coord_t top;
    swc_pkg::coord_t plane_x;
    swc_pkg::coord_t plane_y;
    logic            ok_x;
    logic            ok_y;
  } sb_t;

  // configuration
  logic [swc_pkg::CfgW-1:0] box_hw_q, box_hh_q, ball_hw_q, ball_hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_hw_q  <= '0;
      box_hh_q  <= '0;
      ball_hw_q <= '0;
      ball_hh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swc_pkg::RegBoxHalfW:  box_hw_q  <= cfg_data_i;
        swc_pkg::RegBoxHalfH:  box_hh_q  <= cfg_data_i;
        swc_pkg::RegBallHalfW: ball_hw_q <= cfg_data_i;
        swc_pkg::RegBallHalfH: ball_hh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance: output register free or being drained
  logic adv;
  logic out_v_q;
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input unpacking
  swc_pkg::coord_t in_bx, in_by, in_bvx, in_bvy, in_px, in_py, in_pvx, in_pvy;
  swc_pkg::time_t  in_limit;
  assign in_bx    = s_axis_tdata[0*CW +: CW];
  assign in_by    = s_axis_tdata[1*CW +: CW];
  assign in_bvx   = s_axis_tdata[2*CW +: CW];
  assign in_bvy   = s_axis_tdata[3*CW +: CW];
  assign in_px    = s_axis_tdata[4*CW +: CW];
  assign in_py    = s_axis_tdata[5*CW +: CW];
  assign in_pvx   = s_axis_tdata[6*CW +: CW];
  assign in_pvy   = s_axis_tdata[7*CW +: CW];
  assign in_limit = s_axis_tdata[8*CW +: TW];

  // stage 1: grown half sizes, relative velocity
  logic [CW-1:0]   hw_sum, hh_sum;
  logic            v1_q;
  swc_pkg::coord_t bx1_q, by1_q, bvx1_q, bvy1_q, px1_q, py1_q, rvx1_q, rvy1_q;
  swc_pkg::time_t  limit1_q, hw1_q, hh1_q;

  assign hw_sum = {1'b0, box_hw_q} + {1'b0, ball_hw_q};
  assign hh_sum = {1'b0, box_hh_q} + {1'b0, ball_hh_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bx1_q    <= in_bx;
      by1_q    <= in_by;
      bvx1_q   <= in_bvx;
      bvy1_q   <= in_bvy;
      px1_q    <= in_px;
      py1_q    <= in_py;
      limit1_q <= in_limit;
      hw1_q    <= hw_sum[CW-1] ? {TW{1'b1}} : hw_sum[TW-1:0];
      hh1_q    <= hh_sum[CW-1] ? {TW{1'b1}} : hh_sum[TW-1:0];
      rvx1_q   <= swc_pkg::sat_coord(swc_pkg::sx(in_pvx) - swc_pkg::sx(in_bvx));
      rvy1_q   <= swc_pkg::sat_coord(swc_pkg::sx(in_pvy) - swc_pkg::sx(in_bvy));
    end
  end

  // stage 2: sides of the grown box
  logic            v2_q;
  swc_pkg::coord_t bvx2_q, bvy2_q, px2_q, py2_q, rvx2_q, rvy2_q;
  swc_pkg::coord_t left2_q, right2_q, bottom2_q, top2_q;
  swc_pkg::time_t  limit2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bvx2_q    <= bvx1_q;
      bvy2_q    <= bvy1_q;
      px2_q     <= px1_q;
      py2_q     <= py1_q;
      rvx2_q    <= rvx1_q;
      rvy2_q    <= rvy1_q;
      limit2_q  <= limit1_q;
      left2_q   <= swc_pkg::sat_coord(swc_pkg::sx(bx1_q) - $signed({3'b000, hw1_q}));
      right2_q  <= swc_pkg::sat_coord(swc_pkg::sx(bx1_q) + $signed({3'b000, hw1_q}));
      bottom2_q <= swc_pkg::sat_coord(swc_pkg::sx(by1_q) - $signed({3'b000, hh1_q}));
      top2_q    <= swc_pkg::sat_coord(swc_pkg::sx(by1_q) + $signed({3'b000, hh1_q}));
    end
  end

  // stage 3 (into the dividers): facing plane, distance, direction check
  swc_pkg::coord_t plane_x, plane_y;
  swc_pkg::wide_t  num_x, num_y;
  logic            pos_x, pos_y, ok_x, ok_y;
  sb_t             sb_in;

  always_comb begin
    pos_x   = rvx2_q > 0;
    pos_y   = rvy2_q > 0;
    plane_x = pos_x ? left2_q : right2_q;
    plane_y = pos_y ? bottom2_q : top2_q;
    num_x   = swc_pkg::sx(plane_x) - swc_pkg::sx(px2_q);
    num_y   = swc_pkg::sx(plane_y) - swc_pkg::sx(py2_q);
    // a plane behind the motion gives a negative time: no test
    ok_x    = (rvx2_q != 0) && !(num_x < 0 && pos_x) && !(num_x > 0 && !pos_x);
    ok_y    = (rvy2_q != 0) && !(num_y < 0 && pos_y) && !(num_y > 0 && !pos_y);
    sb_in   = '{limit: limit2_q, bvx: bvx2_q, bvy: bvy2_q, px: px2_q, py: py2_q,
                rvx: rvx2_q, rvy: rvy2_q, left: left2_q, right: right2_q,
                bottom: bottom2_q, top: top2_q, plane_x: plane_x,
                plane_y: plane_y, ok_x: ok_x, ok_y: ok_y};
  end

  swc_pkg::time_t t_x, t_y;

  swc_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (swc_pkg::mag_wide(num_x)),
    .den_i (swc_pkg::mag(rvx2_q)),
    .quo_o (t_x)
  );

  swc_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (swc_pkg::mag_wide(num_y)),
    .den_i (swc_pkg::mag(rvy2_q)),
    .quo_o (t_y)
  );

  // sideband delay line matching the divider depth
  logic sbv_q [swc_pkg::DivLat];
  sb_t  sb_q  [swc_pkg::DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < swc_pkg::DivLat; k++) begin
        sbv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      sbv_q[0] <= v2_q;
      for (int k = 1; k < swc_pkg::DivLat; k++) begin
        sbv_q[k] <= sbv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= sb_in;
      for (int k = 1; k < swc_pkg::DivLat; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  sb_t sb_div;
  assign sb_div = sb_q[swc_pkg::DivLat-1];

  // stage 4: crossing offset products, time times other-axis velocity
  logic            v4_q, v5_q, v6_q;
  sb_t             sb4_q, sb5_q, sb6_q;
  swc_pkg::time_t  tx4_q, ty4_q, tx5_q, ty5_q, tx6_q, ty6_q;
  swc_pkg::prod_t  mx4_q, my4_q;
  swc_pkg::sprod_t ox5_q, oy5_q;
  swc_pkg::coord_t crx6_q, cry6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v4_q <= sbv_q[swc_pkg::DivLat-1];
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 4
      sb4_q  <= sb_div;
      tx4_q  <= t_x;
      ty4_q  <= t_y;
      mx4_q  <= t_x * swc_pkg::mag(sb_div.rvy);
      my4_q  <= t_y * swc_pkg::mag(sb_div.rvx);
      // stage 5: back to Q with clamp and sign
      sb5_q  <= sb4_q;
      tx5_q  <= tx4_q;
      ty5_q  <= ty4_q;
      ox5_q  <= swc_pkg::qmul_fin(mx4_q, sb4_q.rvy[CW-1]);
      oy5_q  <= swc_pkg::qmul_fin(my4_q, sb4_q.rvx[CW-1]);
      // stage 6: crossing point on the other axis
      sb6_q  <= sb5_q;
      tx6_q  <= tx5_q;
      ty6_q  <= ty5_q;
      crx6_q <= swc_pkg::sat_coord(swc_pkg::sx(sb5_q.py) + {ox5_q[CW], ox5_q});
      cry6_q <= swc_pkg::sat_coord(swc_pkg::sx(sb5_q.px) + {oy5_q[CW], oy5_q});
    end
  end

  // stage 7: extent checks and earliest side, y axis first
  logic            hit_y, hit_x, hit7;
  swc_pkg::time_t  best_y, best7;
  logic [2:0]      side7;
  swc_pkg::coord_t cx7, cy7;

  always_comb begin
    hit_y  = sb6_q.ok_y && (cry6_q >= sb6_q.left) && (cry6_q <= sb6_q.right) &&
             (ty6_q < sb6_q.limit);
    best_y = hit_y ? ty6_q : sb6_q.limit;
    // x replaces y only when strictly earlier
    hit_x  = sb6_q.ok_x && (crx6_q >= sb6_q.bottom) && (crx6_q <= sb6_q.top) &&
             (tx6_q < best_y);
    hit7   = hit_x || hit_y;
    if (hit_x) begin
      best7 = tx6_q;
      side7 = (sb6_q.rvx > 0) ? swc_pkg::SideLeft : swc_pkg::SideRight;
      cx7   = sb6_q.plane_x;
      cy7   = crx6_q;
    end else if (hit_y) begin
      best7 = ty6_q;
      side7 = (sb6_q.rvy > 0) ? swc_pkg::SideBottom : swc_pkg::SideTop;
      cx7   = cry6_q;
      cy7   = sb6_q.plane_y;
    end else begin
      best7 = sb6_q.limit;
      side7 = swc_pkg::SideNone;
      cx7   = '0;
      cy7   = '0;
    end
  end

  logic            v7_q, v8_q, v9_q;
  logic            hit7_q, hit8_q, hit9_q;
  logic [2:0]      side7_q, side8_q, side9_q;
  swc_pkg::time_t  best7_q, best8_q, best9_q;
  swc_pkg::coord_t cx7_q, cy7_q, cx8_q, cy8_q, cx9_q, cy9_q, bvx7_q, bvy7_q;
  swc_pkg::prod_t  mcx8_q, mcy8_q;
  logic            ncx8_q, ncy8_q;
  swc_pkg::sprod_t ocx9_q, ocy9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv) begin
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit7_q  <= hit7;
      side7_q <= side7;
      best7_q <= best7;
      cx7_q   <= cx7;
      cy7_q   <= cy7;
      bvx7_q  <= sb6_q.bvx;
      bvy7_q  <= sb6_q.bvy;
      // stage 8: box motion over the hit time
      hit8_q  <= hit7_q;
      side8_q <= side7_q;
      best8_q <= best7_q;
      cx8_q   <= cx7_q;
      cy8_q   <= cy7_q;
      mcx8_q  <= best7_q * swc_pkg::mag(bvx7_q);
      mcy8_q  <= best7_q * swc_pkg::mag(bvy7_q);
      ncx8_q  <= bvx7_q[CW-1];
      ncy8_q  <= bvy7_q[CW-1];
      // stage 9
      hit9_q  <= hit8_q;
      side9_q <= side8_q;
      best9_q <= best8_q;
      cx9_q   <= cx8_q;
      cy9_q   <= cy8_q;
      ocx9_q  <= swc_pkg::qmul_fin(mcx8_q, ncx8_q);
      ocy9_q  <= swc_pkg::qmul_fin(mcy8_q, ncy8_q);
    end
  end

  // output register: contact shifted into the world frame on a hit
  logic            hit_q;
  logic [2:0]      side_q;
  swc_pkg::time_t  hit_time_q;
  swc_pkg::coord_t contact_x_q, contact_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q      <= hit9_q;
      side_q     <= side9_q;
      hit_time_q <= best9_q;
      contact_x_q <= hit9_q ?
          swc_pkg::sat_coord(swc_pkg::sx(cx9_q) + {ocx9_q[CW], ocx9_q}) : cx9_q;
      contact_y_q <= hit9_q ?
          swc_pkg::sat_coord(swc_pkg::sx(cy9_q) + {ocy9_q[CW], ocy9_q}) : cy9_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b0, contact_y_q, contact_x_q, hit_time_q, side_q, hit_q};

endmodule

@@ tb/sv/swept_box_collision_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_unit_tb
// self-checking bench for the swept box versus ball hit test
// ----------------------------------------------------------------------------
// Drives box/ball pairs on the input stream and predicts each result with an
// independent Q16.16 model of the swept test. Results are compared field by
// field in order. Phases vary the half sizes, sender gaps and receiver
// stalls, and one phase holds the output off long enough to fill the
// pipeline and stall the input.
// ----------------------------------------------------------------------------
module swept_box_collision_unit_tb;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] box_x, box_y, box_vx, box_vy;
    logic signed [31:0] ball_x, ball_y, ball_vx, ball_vy;
    logic [30:0]        limit;
  } pair_t;

  typedef struct {
    logic               hit;
    logic [2:0]         side;
    logic [30:0]        hit_time;
    logic signed [31:0] cx, cy;
  } outcome_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [swc_pkg::RegIdxW-1:0] cfg_idx_i;
  logic [swc_pkg::CfgW-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  // box_x, box_y, box_vel_x, box_vel_y, ball_x, ball_y, ball_vel_x,
  // ball_vel_y, time_limit, zero pad
  logic [287:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  // hit, side, hit_time, contact_x, contact_y, zero pad
  logic [103:0] m_axis_tdata;

  swept_box_collision_unit dut (.*);

  // predictor copy of the half size registers
  longint unsigned box_hw, box_hh, ball_hw, ball_hh;

  outcome_t pending_outcomes[$];
  int errors;
  int sender_idle_pct, receiver_stall_pct;
  int hold_off_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp_q(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint unsigned abs_q(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // product truncated toward zero, then saturated
  function automatic longint mul_q(longint a, longint b);
    longint unsigned m;
    longint r;
    m = abs_q(a) * abs_q(b);
    m = m >> 16;
    if (m > 64'd2147483648) m = 64'd2147483648;
    r = m;
    if ((a < 0) != (b < 0)) r = -r;
    return clamp_q(r);
  endfunction

  // long division with 16 fraction bits, saturated to the top of the range
  function automatic longint div_q(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q > (QMax >> 16)) return QMax;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    if (q > QMax) q = QMax;
    return q;
  endfunction

  // tests the face that the relative motion along one axis runs into
  function automatic bit face_hit(longint p, longint v, longint lo_face, longint hi_face,
                                  longint q, longint w, longint q_lo, longint q_hi,
                                  longint best, output longint t, output longint plane,
                                  output longint crossing);
    longint gap;
    t = 0;
    plane = 0;
    crossing = 0;
    if (v == 0) return 0;
    plane = v > 0 ? lo_face : hi_face;
    gap = plane - p;
    // moving away from the face: time would be negative
    if ((gap < 0 && v > 0) || (gap > 0 && v < 0)) return 0;
    t = div_q(abs_q(gap), abs_q(v));
    crossing = clamp_q(q + mul_q(t, w));
    if (crossing < q_lo || crossing > q_hi || !(t < best)) return 0;
    return 1;
  endfunction

  function automatic outcome_t predict_collision(pair_t p);
    outcome_t o;
    longint hw, hh, rvx, rvy, left, right, bottom, top;
    longint best, t, plane, crossing, cx, cy;
    hw = clamp_q(box_hw + ball_hw);
    hh = clamp_q(box_hh + ball_hh);
    rvx = clamp_q(longint'(p.ball_vx) - longint'(p.box_vx));
    rvy = clamp_q(longint'(p.ball_vy) - longint'(p.box_vy));
    left = clamp_q(longint'(p.box_x) - hw);
    right = clamp_q(longint'(p.box_x) + hw);
    bottom = clamp_q(longint'(p.box_y) - hh);
    top = clamp_q(longint'(p.box_y) + hh);
    best = p.limit;
    cx = 0;
    cy = 0;
    o.hit = 1'b0;
    o.side = swc_pkg::SideNone;
    // y axis first, x only replaces it when strictly earlier
    if (face_hit(p.ball_y, rvy, bottom, top, p.ball_x, rvx, left, right, best,
                 t, plane, crossing)) begin
      best = t;
      o.side = rvy > 0 ? swc_pkg::SideBottom : swc_pkg::SideTop;
      cx = crossing;
      cy = plane;
      o.hit = 1'b1;
    end
    if (face_hit(p.ball_x, rvx, left, right, p.ball_y, rvy, bottom, top, best,
                 t, plane, crossing)) begin
      best = t;
      o.side = rvx > 0 ? swc_pkg::SideLeft : swc_pkg::SideRight;
      cx = plane;
      cy = crossing;
      o.hit = 1'b1;
    end
    if (o.hit) begin
      // back to the world frame
      cx = clamp_q(cx + mul_q(p.box_vx, best));
      cy = clamp_q(cy + mul_q(p.box_vy, best));
    end
    o.hit_time = best[30:0];
    o.cx = cx[31:0];
    o.cy = cy[31:0];
    return o;
  endfunction

  // ------------------------------------------------------------------ driving
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, p.limit, p.ball_vy, p.ball_vx, p.ball_y, p.ball_x,
                     p.box_vy, p.box_vx, p.box_y, p.box_x};
    // inputs are stable at the falling edge, so tready seen there decides
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    pending_outcomes.push_back(predict_collision(p));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_half_sizes(logic [30:0] bw, logic [30:0] bh, logic [30:0] lw,
                                logic [30:0] lh);
    logic [30:0] vals[4];
    logic [swc_pkg::RegIdxW-1:0] idx[4];
    vals = '{bw, bh, lw, lh};
    idx = '{swc_pkg::RegBoxHalfW, swc_pkg::RegBoxHalfH, swc_pkg::RegBallHalfW,
            swc_pkg::RegBallHalfH};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    box_hw = bw;
    box_hh = bh;
    ball_hw = lw;
    ball_hh = lh;
    @(posedge clk_i);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready <= $urandom_range(99) >= receiver_stall_pct;
    end
  end

  // ----------------------------------------------------------------- checking
  always @(negedge clk_i) begin
    outcome_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tdata[0];
      got.side = m_axis_tdata[3:1];
      got.hit_time = m_axis_tdata[34:4];
      got.cx = m_axis_tdata[66:35];
      got.cy = m_axis_tdata[98:67];
      if (pending_outcomes.size() == 0) begin
        $display("%t unexpected result transfer %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.hit !== want.hit) begin
          $display("%t hit: expected %0d actual %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.side !== want.side) begin
          $display("%t side: expected %0d actual %0d", $time, want.side, got.side);
          errors++;
        end
        if (got.hit_time !== want.hit_time) begin
          $display("%t hit_time: expected %h actual %h", $time, want.hit_time,
                   got.hit_time);
          errors++;
        end
        if (got.cx !== want.cx) begin
          $display("%t contact_x: expected %h actual %h", $time, want.cx, got.cx);
          errors++;
        end
        if (got.cy !== want.cy) begin
          $display("%t contact_y: expected %h actual %h", $time, want.cy, got.cy);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] near(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // mostly pairs on a course toward the box, some fully random noise
  function automatic pair_t random_pair();
    pair_t p;
    if ($urandom_range(99) < 15) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 31'($urandom)};
    end else begin
      p.box_x = near(32'h0100_0000);
      p.box_y = near(32'h0100_0000);
      p.box_vx = $urandom_range(3) == 0 ? 0 : near(32'h0002_0000);
      p.box_vy = $urandom_range(3) == 0 ? 0 : near(32'h0002_0000);
      p.ball_x = p.box_x + near(32'h0040_0000);
      p.ball_y = p.box_y + near(32'h0040_0000);
      // aim roughly at the box centre so many pairs reach a face
      p.ball_vx = p.box_vx + ((p.box_x - p.ball_x) >>> $urandom_range(6)) + near(32'h1_0000);
      p.ball_vy = p.box_vy + ((p.box_y - p.ball_y) >>> $urandom_range(6)) + near(32'h1_0000);
      if ($urandom_range(7) == 0) p.ball_vx = p.box_vx;
      if ($urandom_range(7) == 0) p.ball_vy = p.box_vy;
      p.limit = $urandom_range(3) == 0 ? 31'($urandom)
                                       : 31'($urandom_range(32'h0010_0000));
    end
    return p;
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    set_half_sizes(31'h0001_0000, 31'h0001_0000, 31'h0000_8000, 31'h0000_8000);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_pair('{mx, mx, mx, mx, mx, mx, mx, mx, 31'h7FFF_FFFF});
    send_pair('{mn, mn, mn, mn, mn, mn, mn, mn, 31'h7FFF_FFFF});
    send_pair('{mx, mn, mn, mx, mn, mx, mx, mn, 31'h7FFF_FFFF});
    // falling onto the top face
    send_pair('{0, 0, 0, 0, 0, 32'sh0005_0000, 0, -32'sh0001_0000, 31'h0010_0000});
    // rising into the bottom face
    send_pair('{0, 0, 0, 0, 0, -32'sh0005_0000, 0, 32'sh0001_0000, 31'h0010_0000});
    // moving right into the left face, and left into the right face
    send_pair('{0, 0, 0, 0, -32'sh0005_0000, 0, 32'sh0002_0000, 0, 31'h0010_0000});
    send_pair('{0, 0, 0, 0, 32'sh0005_0000, 0, -32'sh0002_0000, 0, 31'h0010_0000});
    // moving away: negative time
    send_pair('{0, 0, 0, 0, 32'sh0005_0000, 0, 32'sh0002_0000, 0, 31'h0010_0000});
    // zero relative velocity on both axes, box moving with the ball
    send_pair('{0, 0, 32'sh0003_0000, 32'sh0003_0000, 32'sh0005_0000, 0,
                32'sh0003_0000, 32'sh0003_0000, 31'h0010_0000});
    // already touching: distance zero gives time zero
    send_pair('{0, 0, 0, 0, 32'sh0001_8000, 0, -32'sh0001_0000, 0, 31'h0000_0001});
    // time zero with limit zero: not strictly before the limit
    send_pair('{0, 0, 0, 0, 32'sh0001_8000, 0, -32'sh0001_0000, 0, 0});
    // hit exactly at the limit is no hit
    send_pair('{0, 0, 0, 0, 0, 32'sh0002_8000, 0, -32'sh0001_0000, 31'h0001_0000});
    // diagonal corner with equal times on both axes: y is kept
    send_pair('{0, 0, 0, 0, 32'sh0002_8000, 32'sh0002_8000, -32'sh0001_0000,
                -32'sh0001_0000, 31'h0010_0000});
    // crossing just outside the face extent
    send_pair('{0, 0, 0, 0, 32'sh0001_8001, 32'sh0005_0000, 0, -32'sh0001_0000,
                31'h0010_0000});
    // fast box pushes the contact point past the range
    send_pair('{mx - 32'sh0010_0000, 0, mx, 0, mx, 0, 32'sh7000_0000, 0,
                31'h7FFF_FFFF});
    // tiny velocity saturates the hit time
    send_pair('{0, 0, 0, 0, 0, mx, 0, -32'sh0000_0001, 31'h7FFF_FFFF});
    wait_drained();
  endtask

  task automatic test_size_extremes();
    set_half_sizes('0, '0, '0, '0);
    for (int i = 0; i < 20; i++) send_pair(random_pair());
    set_half_sizes(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    for (int i = 0; i < 20; i++) send_pair(random_pair());
    wait_drained();
  endtask

  task automatic test_random_idling();
    int idle[4] = '{0, 49, 0, 16};
    int stall[4] = '{0, 0, 49, 16};
    for (int ph = 0; ph < 4; ph++) begin
      set_half_sizes(31'($urandom_range(32'h0020_0000)), 31'($urandom_range(32'h0020_0000)),
                     31'($urandom_range(32'h0008_0000)), 31'($urandom));
      sender_idle_pct = idle[ph];
      receiver_stall_pct = stall[ph];
      for (int i = 0; i < 100; i++) send_pair(random_pair());
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    set_half_sizes(31'h0004_0000, 31'h0002_0000, 31'h0001_0000, 31'h0001_0000);
    hold_off_cycles = 300;
    for (int i = 0; i < 100; i++) send_pair(random_pair());
    wait_drained();
  endtask

  initial begin
    errors = 0;
    hold_off_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    box_hw = 0;
    box_hh = 0;
    ball_hw = 0;
    ball_hh = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_extremes();
    test_random_idling();
    test_backpressure();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ swept_box_collision_unit.f @@
design/swc_pkg.sv
design/swc_div.sv
design/swept_box_collision_unit.sv
tb/sv/swept_box_collision_unit_tb.sv
